// File: sv/lcdns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer package
// Phase codes, state and configuration types, init table and phase stepping.
// ----------------------------------------------------------------------------
package lcdns_pkg;

    localparam int DELAY_BITS_DEF = 8;
    localparam int CFG_ADDR_BITS  = 5;
    localparam int CHAIN_STEPS    = 3;

    localparam logic [2:0] REG_PULSE       = 3'd0;
    localparam logic [2:0] REG_BYTE_WAIT   = 3'd1;
    localparam logic [2:0] REG_POWER_WAIT  = 3'd2;
    localparam logic [2:0] REG_INIT_WAIT   = 3'd3;
    localparam logic [2:0] REG_CLEAR_EXTRA = 3'd4;

    localparam logic [7:0] RST_PULSE       = 8'd1;
    localparam logic [7:0] RST_BYTE_WAIT   = 8'd10;
    localparam logic [7:0] RST_POWER_WAIT  = 8'd20;
    localparam logic [7:0] RST_INIT_WAIT   = 8'd10;
    localparam logic [7:0] RST_CLEAR_EXTRA = 8'd5;

    localparam logic [3:0] STEP_LAST_NIBBLE = 4'd3;
    localparam logic [3:0] STEP_FIRST_BYTE  = 4'd4;
    localparam logic [3:0] STEP_CLEAR       = 4'd6;
    localparam logic [3:0] STEP_LAST_BYTE   = 4'd7;
    localparam logic [3:0] STEP_DONE        = 4'd8;

    localparam logic [3:0] NIB_INIT_THREE = 4'h3;
    localparam logic [3:0] NIB_INIT_TWO   = 4'h2;

    typedef enum logic [3:0] {
        PH_POWER     = 4'd0,
        PH_INIT_HI   = 4'd1,
        PH_INIT_LO   = 4'd2,
        PH_INIT_WAIT = 4'd3,
        PH_HN_HI     = 4'd4,
        PH_HN_LO     = 4'd5,
        PH_LN_HI     = 4'd6,
        PH_LN_LO     = 4'd7,
        PH_SETTLE    = 4'd8,
        PH_EXTRA     = 4'd9,
        PH_IDLE      = 4'd10
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [3:0] init_step;
        logic [7:0] pending_byte;
        logic       rs;
        logic       en;
        logic [3:0] nibble;
    } t_lcd_state;

    typedef struct packed {
        logic [7:0] pulse_ticks;
        logic [7:0] byte_wait_ticks;
        logic [7:0] power_wait_ticks;
        logic [7:0] init_wait_ticks;
        logic [7:0] clear_extra_ticks;
    } t_cfg;

    typedef struct packed {
        logic       rejected;
        logic       busy;
        logic [3:0] nibble;
        logic       en;
        logic       rs;
    } t_result;

    function automatic logic [7:0] init_byte(logic [3:0] step);
        logic [1:0] idx;
        logic [7:0] b;
        idx = 2'(step - STEP_FIRST_BYTE);
        case (idx)
            2'd0: b = 8'h28;
            2'd1: b = 8'h0C;
            2'd2: b = 8'h01;
            default: b = 8'h06;
        endcase
        return b;
    endfunction

    function automatic t_lcd_state begin_byte(t_lcd_state s, logic [7:0] b, logic rs);
        t_lcd_state r;
        r = s;
        r.pending_byte = b;
        r.rs = rs;
        r.nibble = b[7:4];
        r.en = 1'b1;
        r.phase = PH_HN_HI;
        return r;
    endfunction

    function automatic t_lcd_state next_phase(t_lcd_state s);
        t_lcd_state r;
        r = s;
        case (s.phase)
            PH_POWER: begin
                r.init_step = 4'd0;
                r.rs = 1'b0;
                r.nibble = NIB_INIT_THREE;
                r.en = 1'b1;
                r.phase = PH_INIT_HI;
            end
            PH_INIT_HI: begin
                r.en = 1'b0;
                r.phase = PH_INIT_LO;
            end
            PH_INIT_LO: begin
                if (s.init_step < STEP_LAST_NIBBLE) begin
                    r.phase = PH_INIT_WAIT;
                end else begin
                    r.init_step = STEP_FIRST_BYTE;
                    r = begin_byte(r, init_byte(STEP_FIRST_BYTE), 1'b0);
                end
            end
            PH_INIT_WAIT: begin
                r.init_step = s.init_step + 4'd1;
                r.nibble = (r.init_step == STEP_LAST_NIBBLE) ? NIB_INIT_TWO : NIB_INIT_THREE;
                r.en = 1'b1;
                r.phase = PH_INIT_HI;
            end
            PH_HN_HI: begin
                r.en = 1'b0;
                r.phase = PH_HN_LO;
            end
            PH_HN_LO: begin
                r.nibble = s.pending_byte[3:0];
                r.en = 1'b1;
                r.phase = PH_LN_HI;
            end
            PH_LN_HI: begin
                r.en = 1'b0;
                r.phase = PH_LN_LO;
            end
            PH_LN_LO: begin
                r.phase = PH_SETTLE;
            end
            PH_SETTLE: begin
                if (s.init_step == STEP_CLEAR) begin
                    r.phase = PH_EXTRA;
                end else if (s.init_step >= STEP_FIRST_BYTE && s.init_step < STEP_LAST_BYTE) begin
                    r.init_step = s.init_step + 4'd1;
                    r = begin_byte(r, init_byte(r.init_step), 1'b0);
                end else begin
                    r.init_step = STEP_DONE;
                    r.phase = PH_IDLE;
                end
            end
            PH_EXTRA: begin
                r.init_step = STEP_LAST_BYTE;
                r = begin_byte(r, init_byte(STEP_LAST_BYTE), 1'b0);
            end
            default: begin
                r.phase = PH_IDLE;
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: sv/lcdns_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the pulse and wait durations.
// ----------------------------------------------------------------------------
module lcdns_cfg_regs import lcdns_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready,
    output t_cfg                          o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;
    logic [7:0] rd_val;

    assign reg_idx = paddr[CFG_ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_ticks       <= RST_PULSE;
            r_cfg.byte_wait_ticks   <= RST_BYTE_WAIT;
            r_cfg.power_wait_ticks  <= RST_POWER_WAIT;
            r_cfg.init_wait_ticks   <= RST_INIT_WAIT;
            r_cfg.clear_extra_ticks <= RST_CLEAR_EXTRA;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PULSE:       r_cfg.pulse_ticks       <= pwdata[7:0];
                REG_BYTE_WAIT:   r_cfg.byte_wait_ticks   <= pwdata[7:0];
                REG_POWER_WAIT:  r_cfg.power_wait_ticks  <= pwdata[7:0];
                REG_INIT_WAIT:   r_cfg.init_wait_ticks   <= pwdata[7:0];
                REG_CLEAR_EXTRA: r_cfg.clear_extra_ticks <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PULSE:       rd_val = r_cfg.pulse_ticks;
            REG_BYTE_WAIT:   rd_val = r_cfg.byte_wait_ticks;
            REG_POWER_WAIT:  rd_val = r_cfg.power_wait_ticks;
            REG_INIT_WAIT:   rd_val = r_cfg.init_wait_ticks;
            REG_CLEAR_EXTRA: rd_val = r_cfg.clear_extra_ticks;
            default:         rd_val = 8'd0;
        endcase
        prdata = {24'd0, rd_val};
    end

endmodule
`default_nettype wire

// File: sv/lcdns_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sequencer core
// Phase state machine and tick counter, updated once per word.
// ----------------------------------------------------------------------------
module lcdns_core import lcdns_pkg::*; #(
    parameter int DELAY_BITS = DELAY_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic       i_func,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_is_data,
    input  t_cfg            i_cfg,
    output t_result         o_result
);

    localparam int CW = (DELAY_BITS > 8) ? DELAY_BITS : 8;
    localparam logic [DELAY_BITS-1:0] DMAX = {DELAY_BITS{1'b1}};

    t_lcd_state            r_state;
    t_lcd_state            n_state;
    logic [DELAY_BITS-1:0] r_wait;
    logic [DELAY_BITS-1:0] n_wait;
    logic                  reject;

    function automatic logic [DELAY_BITS-1:0] clamp_dur(logic [7:0] v);
        logic [CW-1:0] ve;
        logic [CW-1:0] me;
        ve = CW'(v);
        me = CW'(DMAX);
        return (ve > me) ? DELAY_BITS'(me) : DELAY_BITS'(ve);
    endfunction

    function automatic logic [DELAY_BITS-1:0] phase_dur(t_phase p, t_cfg c);
        logic [DELAY_BITS-1:0] d;
        case (p)
            PH_POWER:     d = clamp_dur(c.power_wait_ticks);
            PH_INIT_WAIT: d = clamp_dur(c.init_wait_ticks);
            PH_SETTLE:    d = clamp_dur(c.byte_wait_ticks);
            PH_EXTRA:     d = clamp_dur(c.clear_extra_ticks);
            default: begin
                d = clamp_dur(c.pulse_ticks);
                if (d == '0) begin
                    d = DELAY_BITS'(1);
                end
            end
        endcase
        return d;
    endfunction

    // A zero-length wait phase ends in the same word, so a few transitions may chain.
    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        reject  = 1'b0;
        if (!i_func) begin
            if (r_state.phase != PH_IDLE) begin
                if (n_wait < DMAX) begin
                    n_wait = n_wait + 1'b1;
                end
                for (int k = 0; k < CHAIN_STEPS; k++) begin
                    if (n_state.phase != PH_IDLE &&
                        n_wait >= phase_dur(n_state.phase, i_cfg)) begin
                        n_wait  = '0;
                        n_state = next_phase(n_state);
                    end
                end
            end
        end else if (r_state.phase != PH_IDLE) begin
            reject = 1'b1;
        end else begin
            n_wait  = '0;
            n_state = begin_byte(r_state, i_byte_value, i_is_data);
        end
    end

    always_comb begin
        o_result.rejected = reject;
        o_result.busy     = (n_state.phase != PH_IDLE);
        o_result.nibble   = n_state.nibble;
        o_result.en       = n_state.en;
        o_result.rs       = n_state.rs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_POWER, init_step: 4'd0, pending_byte: 8'd0,
                         rs: 1'b0, en: 1'b0, nibble: 4'd0};
            r_wait  <= '0;
        end else if (i_fire) begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
    end

endmodule
`default_nettype wire

// File: sv/char_lcd_nibble_sequencer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer
// Drives a character LCD over a 4-bit bus from tick and send words.
//
//   Channel  Direction  Contents
//   s_axis   in         tick or send request, byte and register select
//   m_axis   out        pin levels, busy and reject flag, one per input word
//   apb      in/out     pulse and wait durations
//
// One word is accepted every cycle unless m_axis holds back a result. Its result word
// is written to the result register when the word advances out of the input register.
// The input register and the result register form a two-stage pipeline; while
// m_axis holds back a result and the input register is full, s_axis_tready is low.
// Reset is synchronous and starts the power-up wait; no clearing pass.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_unit import lcdns_pkg::*; #(
    parameter int DELAY_BITS = DELAY_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [7:0]               s_axis_tdata,  // byte_value
    input  wire logic [1:0]               s_axis_tuser,  // func, is_data
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic      [7:0]               m_axis_tdata,  // rs_level, en_level,
                                                         // data_nibble, busy_res, rejected
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready
);

    t_cfg       cfg;
    t_result    result;
    logic       advance;
    logic       r_in_valid;
    logic       r_in_func;
    logic       r_in_is_data;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    lcdns_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lcdns_core #(
        .DELAY_BITS (DELAY_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (advance),
        .i_func       (r_in_func),
        .i_byte_value (r_in_byte),
        .i_is_data    (r_in_is_data),
        .i_cfg        (cfg),
        .o_result     (result)
    );

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func    <= s_axis_tuser[0];
            r_in_is_data <= s_axis_tuser[1];
            r_in_byte    <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

endmodule
`default_nettype wire
